// ===== rtl/fmr_pkg.sv =====
// Shared types, constants and CRC function for the framed message receiver.
package fmr_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW = $clog2(CMD_DEPTH);

	localparam logic [2:0] REG_START_CHAR = 3'd0;
	localparam logic [2:0] REG_END_CHAR = 3'd1;
	localparam logic [2:0] REG_ESCAPE_CHAR = 3'd2;
	localparam logic [2:0] REG_ESCAPE_MASK = 3'd3;
	localparam logic [2:0] REG_MIDI_TYPE = 3'd4;

	localparam logic [7:0] START_CHAR_RST = 8'd2;
	localparam logic [7:0] END_CHAR_RST = 8'd3;
	localparam logic [7:0] ESCAPE_CHAR_RST = 8'd125;
	localparam logic [7:0] ESCAPE_MASK_RST = 8'd32;
	localparam logic [15:0] MIDI_TYPE_RST = 16'd0;

	localparam logic [1:0] KIND_BODY = 2'd0;
	localparam logic [1:0] KIND_GOOD = 2'd1;
	localparam logic [1:0] KIND_BAD = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       parity_error;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] message_type;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  start_char;
		logic [7:0]  end_char;
		logic [7:0]  escape_char;
		logic [7:0]  escape_mask;
		logic [15:0] midi_type;
	} cfg_t;

	// request from the front to the back
	typedef struct packed {
		logic        is_end;
		logic        midi;
		logic        good;
		logic [7:0]  data;
		logic [15:0] mtype;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = ~acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return ~r;
	endfunction

endpackage

// ===== rtl/fmr_front.sv =====
// Front end: drops parity errors, unstuffs, tracks the frame and checks the CRC.
module fmr_front
	import fmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     accept,
	input  in_item_t item,
	output logic     cmd_push,
	output cmd_t     cmd
);

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_LEN,
		PH_ID_HI,
		PH_ID_LO,
		PH_BODY,
		PH_CRC,
		PH_END
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        esc_q, esc_d;
	logic [15:0] type_q, type_d;
	logic [7:0]  left_q, left_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] rxcrc_q, rxcrc_d;

	logic        active;
	logic [7:0]  b;
	logic [7:0]  left_dec;
	logic [31:0] crc_next;

	assign active = (phase_q != PH_WAIT);
	assign b = (active && esc_q) ? (item.rx_byte ^ cfg.escape_mask) : item.rx_byte;
	assign left_dec = left_q - 8'd1;
	assign crc_next = crc_byte((phase_q == PH_LEN) ? 32'd0 : crc_q, b);

	always_comb begin
		phase_d = phase_q;
		esc_d = esc_q;
		type_d = type_q;
		left_d = left_q;
		crc_d = crc_q;
		rxcrc_d = rxcrc_q;
		cmd_push = 1'b0;
		cmd = '{is_end: 1'b0, midi: 1'b0, good: 1'b0, data: b, mtype: type_q};
		if (!accept || item.parity_error) begin
			cmd_push = 1'b0;
		end else if (active && !esc_q && item.rx_byte == cfg.escape_char) begin
			esc_d = 1'b1;
		end else if (!esc_q && ((b == cfg.start_char && active) ||
			(b == cfg.end_char && phase_q != PH_END) || b == cfg.escape_char)) begin
			phase_d = PH_WAIT;
			esc_d = 1'b0;
			left_d = 8'd0;
		end else begin
			esc_d = 1'b0;
			unique case (phase_q)
				PH_WAIT: begin
					if (b == cfg.start_char)
						phase_d = PH_LEN;
				end
				PH_LEN: begin
					left_d = b;
					crc_d = crc_next;
					phase_d = PH_ID_HI;
				end
				PH_ID_HI: begin
					type_d = {b, 8'd0};
					left_d = left_dec;
					crc_d = crc_next;
					phase_d = PH_ID_LO;
				end
				PH_ID_LO: begin
					type_d = {type_q[15:8], b};
					crc_d = crc_next;
					if (left_dec != 8'd0) begin
						left_d = left_dec;
						phase_d = PH_BODY;
					end else begin
						left_d = 8'd4;
						phase_d = PH_CRC;
					end
				end
				PH_BODY: begin
					cmd_push = 1'b1;
					crc_d = crc_next;
					if (left_dec == 8'd0) begin
						left_d = 8'd4;
						phase_d = PH_CRC;
					end else begin
						left_d = left_dec;
					end
				end
				PH_CRC: begin
					left_d = left_dec;
					rxcrc_d = {rxcrc_q[23:0], b};
					if (left_dec == 8'd0)
						phase_d = PH_END;
				end
				PH_END: begin
					cmd_push = 1'b1;
					cmd.is_end = 1'b1;
					cmd.midi = (type_q == cfg.midi_type);
					cmd.good = (rxcrc_q == crc_q);
					cmd.data = 8'd0;
					type_d = 16'd0;
					left_d = 8'd0;
					phase_d = PH_WAIT;
				end
				default: phase_d = PH_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			esc_q <= 1'b0;
			type_q <= 16'd0;
			left_q <= 8'd0;
			crc_q <= 32'd0;
			rxcrc_q <= 32'd0;
		end else begin
			phase_q <= phase_d;
			esc_q <= esc_d;
			type_q <= type_d;
			left_q <= left_d;
			crc_q <= crc_d;
			rxcrc_q <= rxcrc_d;
		end
	end

endmodule

// ===== rtl/fmr_cmd_fifo.sv =====
// Short request queue between the front end and the back end.
module fmr_cmd_fifo
	import fmr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic empty,
	output logic full
);

	cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wptr_q;
	logic [CMD_AW-1:0] rptr_q;
	logic [CMD_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (CMD_AW+1)'(CMD_DEPTH));
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (rd && !wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/fmr_back.sv =====
// Back end: expands requests into result items behind an output register.
module fmr_back
	import fmr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	logic      out_valid_q;
	out_item_t out_q;
	logic [1:0] cnt_q;
	logic      load;
	logic      done;
	out_item_t nxt;

	assign load = !cmd_empty && (!out_valid_q || pop);
	assign done = !cmd.is_end || !cmd.midi || (cnt_q == 2'd3);
	assign cmd_pop = load && done;
	assign empty = !out_valid_q;
	assign result = out_q;

	always_comb begin
		nxt.message_type = cmd.mtype;
		if (!cmd.is_end) begin
			nxt.kind = KIND_BODY;
			nxt.data = cmd.data;
			nxt.last = 1'b1;
		end else if (!done) begin
			nxt.kind = KIND_BODY;
			nxt.data = 8'd0;
			nxt.last = 1'b0;
		end else begin
			nxt.kind = cmd.good ? KIND_GOOD : KIND_BAD;
			nxt.data = 8'd0;
			nxt.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load)
				cnt_q <= done ? 2'd0 : cnt_q + 2'd1;
		end
	end

endmodule

// ===== rtl/framed_message_receiver_top.sv =====
// Top level of the framed message receiver: config registers and the front/back split.
// A byte's result passes through the request queue and then the output register before it appears on the result ports.
// Throughput: one byte per cycle while full is low and one result per cycle while results are popped; a frame end
// of the MIDI type gives four results from one request, so the back end holds it until the last one is loaded.
// full rises once all 4 entries of the request queue are taken; the output register holds one more.
// Reset (arst_n low) clears frame state, queue and output at once; no clearing pass.
module framed_message_receiver_top
	import fmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    rx_item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_pop;
	logic cmd_empty;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char <= START_CHAR_RST;
			cfg_q.end_char <= END_CHAR_RST;
			cfg_q.escape_char <= ESCAPE_CHAR_RST;
			cfg_q.escape_mask <= ESCAPE_MASK_RST;
			cfg_q.midi_type <= MIDI_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_START_CHAR:  cfg_q.start_char <= cfg_data[7:0];
				REG_END_CHAR:    cfg_q.end_char <= cfg_data[7:0];
				REG_ESCAPE_CHAR: cfg_q.escape_char <= cfg_data[7:0];
				REG_ESCAPE_MASK: cfg_q.escape_mask <= cfg_data[7:0];
				REG_MIDI_TYPE:   cfg_q.midi_type <= cfg_data;
				default: ;
			endcase
		end
	end

	fmr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.item     (rx_item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	fmr_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.rd     (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty),
		.full   (full)
	);

	fmr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// ===== tb/sv/framed_message_receiver_chk.sv =====
// Checker for the framed message receiver: predicts results from the accepted bytes and compares them.
module framed_message_receiver_chk
	import fmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  in_item_t    rx_item,
	input  logic        empty,
	input  logic        pop,
	input  out_item_t   result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);

	typedef enum logic [2:0] {
		F_WAIT, F_LEN, F_TYPE_HI, F_TYPE_LO, F_BODY, F_CRC, F_END
	} frame_phase_t;

	cfg_t         regs;
	frame_phase_t phase;
	logic         esc_pending;
	logic [15:0]  cur_type;
	logic [7:0]   left;
	logic [31:0]  crc_acc;
	logic [31:0]  crc_rx;
	out_item_t    expected_q[$];
	out_item_t    want;
	int           fails = 0;

	assign fail_count = fails;
	assign outstanding = expected_q.size();

	function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		logic fb;
		c = ~acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return ~c;
	endfunction

	task automatic add_expected(input logic [1:0] k, input logic [7:0] d, input logic fin);
		out_item_t o;
		o.kind = k;
		o.data = d;
		o.message_type = cur_type;
		o.last = fin;
		expected_q.push_back(o);
	endtask

	task automatic predict_byte(input in_item_t it);
		logic [7:0] b;
		b = it.rx_byte;
		if (it.parity_error) begin
			return;
		end
		if (phase != F_WAIT) begin
			if (esc_pending) begin
				b = b ^ regs.escape_mask;
			end else if (b == regs.escape_char) begin
				esc_pending = 1'b1;
				return;
			end
		end
		// misplaced control byte drops the frame silently
		if (!esc_pending && ((b == regs.start_char && phase != F_WAIT) ||
				(b == regs.end_char && phase != F_END) || b == regs.escape_char)) begin
			phase = F_WAIT;
			esc_pending = 1'b0;
			left = 8'd0;
			return;
		end
		esc_pending = 1'b0;
		case (phase)
			F_WAIT: begin
				if (b == regs.start_char) begin
					phase = F_LEN;
				end
			end
			F_LEN: begin
				left = b;
				crc_acc = crc_next(32'd0, b);
				phase = F_TYPE_HI;
			end
			F_TYPE_HI: begin
				cur_type = {b, 8'd0};
				left = left - 8'd1;
				crc_acc = crc_next(crc_acc, b);
				phase = F_TYPE_LO;
			end
			F_TYPE_LO: begin
				cur_type = cur_type | {8'd0, b};
				left = left - 8'd1;
				crc_acc = crc_next(crc_acc, b);
				if (left != 8'd0) begin
					phase = F_BODY;
				end else begin
					phase = F_CRC;
					left = 8'd4;
				end
			end
			F_BODY: begin
				add_expected(KIND_BODY, b, 1'b1);
				left = left - 8'd1;
				crc_acc = crc_next(crc_acc, b);
				if (left == 8'd0) begin
					phase = F_CRC;
					left = 8'd4;
				end
			end
			F_CRC: begin
				left = left - 8'd1;
				crc_rx = {crc_rx[23:0], b};
				if (left == 8'd0) begin
					phase = F_END;
				end
			end
			default: begin
				if (cur_type == regs.midi_type) begin
					repeat (3) add_expected(KIND_BODY, 8'd0, 1'b0);
				end
				add_expected((crc_rx == crc_acc) ? KIND_GOOD : KIND_BAD, 8'd0, 1'b1);
				phase = F_WAIT;
				cur_type = 16'd0;
				left = 8'd0;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v, input logic [15:0] got);
		if (exp_v !== got) begin
			fails++;
			$display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{START_CHAR_RST, END_CHAR_RST, ESCAPE_CHAR_RST, ESCAPE_MASK_RST,
				MIDI_TYPE_RST};
			phase = F_WAIT;
			esc_pending = 1'b0;
			cur_type = 16'd0;
			left = 8'd0;
			crc_acc = 32'd0;
			crc_rx = 32'd0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_START_CHAR:  regs.start_char = cfg_data[7:0];
					REG_END_CHAR:    regs.end_char = cfg_data[7:0];
					REG_ESCAPE_CHAR: regs.escape_char = cfg_data[7:0];
					REG_ESCAPE_MASK: regs.escape_mask = cfg_data[7:0];
					REG_MIDI_TYPE:   regs.midi_type = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				predict_byte(rx_item);
			end
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result expected none actual %h", $time, result);
				end else begin
					want = expected_q.pop_front();
					check_field("kind", 16'(want.kind), 16'(result.kind));
					check_field("data", 16'(want.data), 16'(result.data));
					check_field("message_type", want.message_type, result.message_type);
					check_field("last", 16'(want.last), 16'(result.last));
				end
			end
		end
	end

endmodule

// ===== tb/sv/framed_message_receiver_top_tb.sv =====
// Testbench top for the framed message receiver: clock, reset, frame stimulus and verdict.
module framed_message_receiver_top_tb
	import fmr_pkg::*;
;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BYTES = 75;
	localparam int END_PLAIN = 0;
	localparam int END_OTHER = 1;
	localparam int END_ESCAPED = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    rx_item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = REG_START_CHAR;
	logic [15:0] cfg_data = 16'd0;
	int          fail_count;
	int          outstanding;

	int          send_idle_pct = 10;
	int          recv_stall_pct = 45;
	int          bytes_sent = 0;
	int          random_base = 0;
	cfg_t        cur_cfg;
	logic [7:0]  frame_q[$];

	framed_message_receiver_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .rx_item(rx_item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	framed_message_receiver_chk chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .rx_item(rx_item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	function automatic logic [31:0] frame_crc(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = ~acc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

	function automatic logic is_ctrl(input logic [7:0] b);
		return b == cur_cfg.start_char || b == cur_cfg.end_char || b == cur_cfg.escape_char;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic pe);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		rx_item <= '{rx_byte: b, parity_error: pe};
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		if (!pe) begin
			bytes_sent++;
		end
	endtask

	task automatic put_stuffed(input logic [7:0] b);
		if (is_ctrl(b)) begin
			frame_q.push_back(cur_cfg.escape_char);
			frame_q.push_back(b ^ cur_cfg.escape_mask);
		end else begin
			frame_q.push_back(b);
		end
	endtask

	task automatic build_frame(input int body_len, input logic [15:0] mtype, input bit good,
			input int end_style);
		logic [31:0] crc;
		logic [7:0] len;
		logic [7:0] v;
		frame_q.delete();
		len = 8'(body_len + 2);
		frame_q.push_back(cur_cfg.start_char);
		crc = frame_crc(32'd0, len);
		put_stuffed(len);
		crc = frame_crc(crc, mtype[15:8]);
		put_stuffed(mtype[15:8]);
		crc = frame_crc(crc, mtype[7:0]);
		put_stuffed(mtype[7:0]);
		for (int i = 0; i < body_len; i++) begin
			case ($urandom_range(7))
				0: v = cur_cfg.start_char;
				1: v = cur_cfg.end_char;
				2: v = cur_cfg.escape_char;
				default: v = 8'($urandom);
			endcase
			crc = frame_crc(crc, v);
			put_stuffed(v);
		end
		if (!good) begin
			crc = crc ^ (32'd1 << $urandom_range(31));
		end
		for (int i = 3; i >= 0; i--) begin
			put_stuffed(crc[8*i +: 8]);
		end
		// end phase takes any byte that does not abort
		if (end_style == END_OTHER) begin
			v = 8'($urandom);
			while (is_ctrl(v)) v = 8'($urandom);
			frame_q.push_back(v);
		end else if (end_style == END_ESCAPED) begin
			frame_q.push_back(cur_cfg.escape_char);
			frame_q.push_back(8'($urandom));
		end else begin
			frame_q.push_back(cur_cfg.end_char);
		end
	endtask

	task automatic send_frame(input int upto, input bit junk);
		for (int i = 0; i < upto; i++) begin
			if (junk && $urandom_range(15) == 0) begin
				send_byte(8'($urandom), 1'b1);
			end
			send_byte(frame_q[i], 1'b0);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= REG_START_CHAR;
		cfg_data <= {8'd0, c.start_char};
		@(negedge clk);
		cfg_idx <= REG_END_CHAR;
		cfg_data <= {8'd0, c.end_char};
		@(negedge clk);
		cfg_idx <= REG_ESCAPE_CHAR;
		cfg_data <= {8'd0, c.escape_char};
		@(negedge clk);
		cfg_idx <= REG_ESCAPE_MASK;
		cfg_data <= {8'd0, c.escape_mask};
		@(negedge clk);
		cfg_idx <= REG_MIDI_TYPE;
		cfg_data <= c.midi_type;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_cfg = c;
	endtask

	task automatic random_traffic(input int quota);
		int stop_at;
		int r;
		int progress;
		logic [15:0] mtype;
		int end_style;
		stop_at = bytes_sent + quota;
		while (bytes_sent < stop_at) begin
			progress = bytes_sent - random_base;
			if (progress < 4 * PHASE_BYTES / 3) begin
				send_idle_pct = 10;
				recv_stall_pct = 45;
			end else if (progress < 8 * PHASE_BYTES / 3) begin
				send_idle_pct = 45;
				recv_stall_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case ($urandom_range(9))
				0, 1, 2: mtype = cur_cfg.midi_type;
				3: mtype = 16'h0000;
				4: mtype = 16'hFFFF;
				default: mtype = 16'($urandom);
			endcase
			case ($urandom_range(9))
				0: end_style = END_OTHER;
				1: end_style = END_ESCAPED;
				default: end_style = END_PLAIN;
			endcase
			build_frame($urandom_range(12), mtype, $urandom_range(4) != 0, end_style);
			r = $urandom_range(99);
			if (r < 75) begin
				send_frame(frame_q.size(), $urandom_range(3) == 0);
			end else if (r < 87) begin
				send_frame($urandom_range(1, frame_q.size() - 1), 1'b0);
				case ($urandom_range(2))
					0: send_byte(cur_cfg.start_char, 1'b0);
					1: send_byte(cur_cfg.end_char, 1'b0);
					default: send_byte(8'($urandom), 1'b0);
				endcase
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(3) == 0);
			end
			if ($urandom_range(39) == 0) begin
				drain();
			end
		end
	endtask

	initial begin
		cur_cfg = '{START_CHAR_RST, END_CHAR_RST, ESCAPE_CHAR_RST, ESCAPE_MASK_RST,
			MIDI_TYPE_RST};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// outside a frame: dropped byte, stray escape, extreme values
		send_byte(8'hFF, 1'b1);
		send_byte(cur_cfg.escape_char, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		build_frame(3, cur_cfg.midi_type, 1'b1, END_PLAIN);
		send_frame(frame_q.size(), 1'b0);
		build_frame(5, 16'hFFFF, 1'b0, END_PLAIN);
		send_frame(frame_q.size(), 1'b1);
		build_frame(0, 16'h0102, 1'b1, END_PLAIN);
		send_frame(frame_q.size(), 1'b0);
		build_frame(2, 16'h8000, 1'b1, END_OTHER);
		send_frame(frame_q.size(), 1'b0);
		build_frame(1, 16'h00FF, 1'b1, END_ESCAPED);
		send_frame(frame_q.size(), 1'b0);
		// start byte inside a frame
		build_frame(4, 16'h5555, 1'b1, END_PLAIN);
		send_frame(4, 1'b0);
		send_byte(cur_cfg.start_char, 1'b0);
		// end byte before the end phase
		build_frame(0, 16'hAAAA, 1'b1, END_PLAIN);
		send_frame(frame_q.size() - 3, 1'b0);
		send_byte(cur_cfg.end_char, 1'b0);
		// length 0 and 1 wrap to long bodies; cut short after a few body bytes
		build_frame(254, cur_cfg.midi_type, 1'b1, END_PLAIN);
		send_frame(12, 1'b0);
		send_byte(cur_cfg.start_char, 1'b0);
		build_frame(255, 16'h7F00, 1'b0, END_PLAIN);
		send_frame(12, 1'b0);
		send_byte(cur_cfg.start_char, 1'b0);

		random_base = bytes_sent;
		random_traffic(PHASE_BYTES);
		apply_cfg('{8'h00, 8'hFF, 8'h80, 8'hFF, 16'hFFFF});
		random_traffic(PHASE_BYTES);
		apply_cfg('{8'hFF, 8'h00, 8'h01, 8'h00, 16'h1234});
		random_traffic(PHASE_BYTES);
		apply_cfg('{8'h7E, 8'h7F, 8'h7D, 8'h20, 16'h8001});
		random_traffic(PHASE_BYTES);

		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fmr_pkg.sv
rtl/fmr_front.sv
rtl/fmr_cmd_fifo.sv
rtl/fmr_back.sv
rtl/framed_message_receiver_top.sv
tb/sv/framed_message_receiver_chk.sv
tb/sv/framed_message_receiver_top_tb.sv
